[hw/rtl/qte_pkg.sv]
// Shared types and constants for the quaternion to Euler angle pipeline.
// Used by every module of the block but qte_dly; no dependencies of its own.
`default_nettype none

package qte_pkg;

    // Port field widths
    localparam int QUAT_W     = 16;
    localparam int YAW_W      = 15;
    localparam int PITCH_W    = 14;
    localparam int ROLL_W     = 15;
    localparam int IN_DATA_W  = 4 * QUAT_W;
    localparam int OUT_DATA_W = 48;

    // Datapath widths
    localparam int PROD_W = 2 * QUAT_W;     // one signed 16x16 product
    localparam int SUM_W  = 35;             // signed sums of products, and the norm
    localparam int CW     = 64;             // CORDIC x and y
    localparam int Z_W    = 32;             // CORDIC angle accumulator
    localparam int T_W    = 33;             // binary angle after quadrant mapping
    localparam int NN_W   = 31;             // normalized norm for the arcsine term
    localparam int SQ_W   = 2 * NN_W;       // square root operand

    // Pipeline shape
    localparam int NORM_STEPS   = 6;
    localparam int NORM_MSB     = 58;
    localparam int CORDIC_STEPS = 30;
    localparam int SQRT_STEPS   = 31;
    localparam int SQRT_TOP_BIT = 60;
    localparam int LEFT_STEPS   = 5;
    localparam int FRONT_LAT    = 2;
    localparam int PREP_LAT     = 4 + LEFT_STEPS + SQRT_STEPS;
    localparam int ATAN_LAT     = NORM_STEPS + CORDIC_STEPS + 2;

    localparam logic signed [Z_W-1:0] QUARTER_TURN = Z_W'(64'd1 << 30);
    localparam logic signed [T_W-1:0] HALF_TURN    = T_W'(64'd1 << 31);
    localparam int DEG_SCALE = 45;

    // atan(2^-i) in binary angle units, 2^32 per turn
    localparam logic signed [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81,
        32'sd41,        32'sd20,        32'sd10,        32'sd5,
        32'sd3,         32'sd1
    };

    typedef struct packed {
        logic signed [SUM_W-1:0] yaw_y;
        logic signed [SUM_W-1:0] yaw_x;
        logic signed [SUM_W-1:0] roll_y;
        logic signed [SUM_W-1:0] roll_x;
    } t_yr_vec;

    typedef struct packed {
        t_yr_vec                 yr;
        logic signed [SUM_W-1:0] pitch_s;
        logic        [SUM_W-1:0] norm;
    } t_sums;

    typedef struct packed {
        logic zero;
        logic neg_x;
        logic neg_y;
    } t_qflags;

    typedef struct packed {
        logic valid;
        logic degen;
    } t_side;

    function automatic logic [SUM_W-1:0] f_mag(input logic signed [SUM_W-1:0] v);
        return v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
    endfunction

endpackage

`default_nettype wire

[hw/rtl/qte_dly.sv]
// Enable-gated register delay line with synchronous clear.
// Uses no package; carries side-band bits and payload alongside the datapath.
`default_nettype none

module qte_dly #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic [WIDTH-1:0] i_data,
    output logic      [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_line [DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_line[k] <= '0;
            end
        end else if (i_en) begin
            r_line[0] <= i_data;
            for (int k = 1; k < DEPTH; k++) begin
                r_line[k] <= r_line[k-1];
            end
        end
    end

    assign o_data = r_line[DEPTH-1];
endmodule

`default_nettype wire

[hw/rtl/qte_front.sv]
// Front end: squares and cross products, then the yaw, roll and pitch terms.
// Two register stages; depends on qte_pkg.
`default_nettype none

module qte_front (
    input  wire logic                              i_clk,
    input  wire logic                              i_en,
    input  wire logic signed [qte_pkg::QUAT_W-1:0] i_quat_real,
    input  wire logic signed [qte_pkg::QUAT_W-1:0] i_quat_i,
    input  wire logic signed [qte_pkg::QUAT_W-1:0] i_quat_j,
    input  wire logic signed [qte_pkg::QUAT_W-1:0] i_quat_k,
    output qte_pkg::t_sums                         o_sums
);
    import qte_pkg::*;

    logic signed [PROD_W-1:0] r_rr, r_ii, r_jj, r_kk;
    logic signed [PROD_W-1:0] r_ij, r_kr, r_jk, r_ir, r_ik, r_jr;
    t_sums r_sums;
    t_sums n_sums;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rr <= PROD_W'(i_quat_real) * PROD_W'(i_quat_real);
            r_ii <= PROD_W'(i_quat_i) * PROD_W'(i_quat_i);
            r_jj <= PROD_W'(i_quat_j) * PROD_W'(i_quat_j);
            r_kk <= PROD_W'(i_quat_k) * PROD_W'(i_quat_k);
            r_ij <= PROD_W'(i_quat_i) * PROD_W'(i_quat_j);
            r_kr <= PROD_W'(i_quat_k) * PROD_W'(i_quat_real);
            r_jk <= PROD_W'(i_quat_j) * PROD_W'(i_quat_k);
            r_ir <= PROD_W'(i_quat_i) * PROD_W'(i_quat_real);
            r_ik <= PROD_W'(i_quat_i) * PROD_W'(i_quat_k);
            r_jr <= PROD_W'(i_quat_j) * PROD_W'(i_quat_real);
        end
    end

    always_comb begin
        n_sums.yr.yaw_y  = (SUM_W'(r_ij) + SUM_W'(r_kr)) <<< 1;
        n_sums.yr.yaw_x  = SUM_W'(r_ii) - SUM_W'(r_jj) - SUM_W'(r_kk) + SUM_W'(r_rr);
        n_sums.yr.roll_y = (SUM_W'(r_jk) + SUM_W'(r_ir)) <<< 1;
        n_sums.yr.roll_x = SUM_W'(r_kk) + SUM_W'(r_rr) - SUM_W'(r_ii) - SUM_W'(r_jj);
        n_sums.pitch_s   = (SUM_W'(r_jr) - SUM_W'(r_ik)) <<< 1;
        n_sums.norm      = SUM_W'(SUM_W'(r_rr) + SUM_W'(r_ii) + SUM_W'(r_jj) + SUM_W'(r_kk));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sums <= n_sums;
        end
    end

    assign o_sums = r_sums;
endmodule

`default_nettype wire

[hw/rtl/qte_pitch.sv]
// Arcsine preparation: clamp, normalize, then sqrt(n^2 - s^2) one bit per stage.
// Depends on qte_pkg; feeds a qte_atan core with (c, |s|).
`default_nettype none

module qte_pitch (
    input  wire logic                             i_clk,
    input  wire logic                             i_en,
    input  wire logic signed [qte_pkg::SUM_W-1:0] i_s,
    input  wire logic        [qte_pkg::SUM_W-1:0] i_norm,
    output logic             [qte_pkg::NN_W-1:0]  o_c,
    output logic             [qte_pkg::NN_W-1:0]  o_a,
    output logic                                  o_neg
);
    import qte_pkg::*;

    localparam int LAST = SQRT_STEPS - 1;

    // clamp
    logic [SUM_W-1:0] r0_nn, r0_a;
    logic             r0_neg;
    logic [SUM_W-1:0] w_mag;

    assign w_mag = f_mag(i_s);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_nn  <= i_norm;
            r0_a   <= (w_mag > i_norm) ? i_norm : w_mag;
            r0_neg <= i_s[SUM_W-1];
        end
    end

    // right normalize: the norm is at most 2^32
    logic [NN_W-1:0] r1_nn, r1_a;
    logic            r1_neg;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r0_nn[NN_W+1]) begin
                r1_nn <= NN_W'(r0_nn >> 2);
                r1_a  <= NN_W'(r0_a >> 2);
            end else if (r0_nn[NN_W]) begin
                r1_nn <= NN_W'(r0_nn >> 1);
                r1_a  <= NN_W'(r0_a >> 1);
            end else begin
                r1_nn <= NN_W'(r0_nn);
                r1_a  <= NN_W'(r0_a);
            end
            r1_neg <= r0_neg;
        end
    end

    // left normalize into [2^30, 2^31)
    logic [NN_W-1:0] r_lnn [LEFT_STEPS];
    logic [NN_W-1:0] r_la  [LEFT_STEPS];
    logic            r_lneg[LEFT_STEPS];

    for (genvar g = 0; g < LEFT_STEPS; g++) begin : g_left
        localparam int SH = 16 >> g;
        logic [NN_W-1:0] w_nn, w_a;
        logic            w_neg;
        if (g == 0) begin : g_first
            assign w_nn  = r1_nn;
            assign w_a   = r1_a;
            assign w_neg = r1_neg;
        end else begin : g_next
            assign w_nn  = r_lnn[g-1];
            assign w_a   = r_la[g-1];
            assign w_neg = r_lneg[g-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_nn < (NN_W'(1) << (NN_W - SH))) begin
                    r_lnn[g] <= w_nn << SH;
                    r_la[g]  <= w_a << SH;
                end else begin
                    r_lnn[g] <= w_nn;
                    r_la[g]  <= w_a;
                end
                r_lneg[g] <= w_neg;
            end
        end
    end

    // squares, then difference
    logic [SQ_W-1:0] r_nn2, r_a2, r_d;
    logic [NN_W-1:0] r2_a, r3_a;
    logic            r2_neg, r3_neg;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nn2  <= SQ_W'(r_lnn[LEFT_STEPS-1]) * SQ_W'(r_lnn[LEFT_STEPS-1]);
            r_a2   <= SQ_W'(r_la[LEFT_STEPS-1]) * SQ_W'(r_la[LEFT_STEPS-1]);
            r2_a   <= r_la[LEFT_STEPS-1];
            r2_neg <= r_lneg[LEFT_STEPS-1];
            r_d    <= r_nn2 - r_a2;
            r3_a   <= r2_a;
            r3_neg <= r2_neg;
        end
    end

    // floor square root, one result bit per stage
    logic [SQ_W-1:0] r_sv [SQRT_STEPS];
    logic [SQ_W-1:0] r_sr [SQRT_STEPS];
    logic [NN_W-1:0] r_sa [SQRT_STEPS];
    logic            r_sneg [SQRT_STEPS];

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQRT_TOP_BIT - 2 * g);
        logic [SQ_W-1:0] w_v, w_r, w_t;
        logic [NN_W-1:0] w_a;
        logic            w_neg;
        if (g == 0) begin : g_first
            assign w_v   = r_d;
            assign w_r   = '0;
            assign w_a   = r3_a;
            assign w_neg = r3_neg;
        end else begin : g_next
            assign w_v   = r_sv[g-1];
            assign w_r   = r_sr[g-1];
            assign w_a   = r_sa[g-1];
            assign w_neg = r_sneg[g-1];
        end
        assign w_t = w_r + BIT;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_v >= w_t) begin
                    r_sv[g] <= w_v - w_t;
                    r_sr[g] <= (w_r >> 1) + BIT;
                end else begin
                    r_sv[g] <= w_v;
                    r_sr[g] <= w_r >> 1;
                end
                r_sa[g]   <= w_a;
                r_sneg[g] <= w_neg;
            end
        end
    end

    assign o_c   = NN_W'(r_sr[LAST]);
    assign o_a   = r_sa[LAST];
    assign o_neg = r_sneg[LAST];
endmodule

`default_nettype wire

[hw/rtl/qte_atan.sv]
// Pipelined first-quadrant CORDIC arctangent with quadrant mapping and
// conversion to degree units. Depends on qte_pkg.
`default_nettype none

module qte_atan #(
    parameter int ANGLE_FRAC_BITS = 6
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic [qte_pkg::CW-1:0]    i_ax,
    input  wire logic [qte_pkg::CW-1:0]    i_ay,
    input  wire logic                      i_neg_x,
    input  wire logic                      i_neg_y,
    output logic signed [ANGLE_FRAC_BITS+9:0] o_angle
);
    import qte_pkg::*;

    localparam int ANG_W  = ANGLE_FRAC_BITS + 10;
    localparam int MUL_W  = T_W + 7;
    localparam int RND_SH = 29 - ANGLE_FRAC_BITS;
    localparam logic signed [MUL_W-1:0] RND = MUL_W'(64'd1 << (RND_SH - 1));

    // normalize: shift both up until the larger has bit 57 set
    logic [CW-1:0] r_nax [NORM_STEPS];
    logic [CW-1:0] r_nay [NORM_STEPS];
    t_qflags       r_nflg[NORM_STEPS];

    for (genvar g = 0; g < NORM_STEPS; g++) begin : g_norm
        localparam int SH = 32 >> g;
        logic [CW-1:0] w_ax, w_ay;
        t_qflags       w_flg;
        if (g == 0) begin : g_first
            assign w_ax  = i_ax;
            assign w_ay  = i_ay;
            assign w_flg = '{zero: (i_ax == '0) && (i_ay == '0),
                             neg_x: i_neg_x, neg_y: i_neg_y};
        end else begin : g_next
            assign w_ax  = r_nax[g-1];
            assign w_ay  = r_nay[g-1];
            assign w_flg = r_nflg[g-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if ((w_ax | w_ay) < (CW'(1) << (NORM_MSB - SH))) begin
                    r_nax[g] <= w_ax << SH;
                    r_nay[g] <= w_ay << SH;
                end else begin
                    r_nax[g] <= w_ax;
                    r_nay[g] <= w_ay;
                end
                r_nflg[g] <= w_flg;
            end
        end
    end

    // vectoring iterations, one per stage
    logic signed [CW-1:0]  r_x [CORDIC_STEPS];
    logic signed [CW-1:0]  r_y [CORDIC_STEPS];
    logic signed [Z_W-1:0] r_z [CORDIC_STEPS];
    t_qflags               r_cflg[CORDIC_STEPS];

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        logic signed [CW-1:0]  w_x, w_y, w_dx, w_dy;
        logic signed [Z_W-1:0] w_z;
        t_qflags               w_flg;
        if (g == 0) begin : g_first
            assign w_x   = signed'(r_nax[NORM_STEPS-1]);
            assign w_y   = signed'(r_nay[NORM_STEPS-1]);
            assign w_z   = '0;
            assign w_flg = r_nflg[NORM_STEPS-1];
        end else begin : g_next
            assign w_x   = r_x[g-1];
            assign w_y   = r_y[g-1];
            assign w_z   = r_z[g-1];
            assign w_flg = r_cflg[g-1];
        end
        assign w_dx = w_y >>> g;
        assign w_dy = w_x >>> g;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!w_y[CW-1]) begin
                    r_x[g] <= w_x + w_dx;
                    r_y[g] <= w_y - w_dy;
                    r_z[g] <= w_z + ATAN_TAB[g];
                end else begin
                    r_x[g] <= w_x - w_dx;
                    r_y[g] <= w_y + w_dy;
                    r_z[g] <= w_z - ATAN_TAB[g];
                end
                r_cflg[g] <= w_flg;
            end
        end
    end

    // clamp and map to quadrant
    logic signed [Z_W-1:0] w_zc;
    logic signed [T_W-1:0] n_t, r_t;
    t_qflags               w_qflg;

    assign w_qflg = r_cflg[CORDIC_STEPS-1];

    always_comb begin
        w_zc = r_z[CORDIC_STEPS-1];
        if (w_zc < 0) begin
            w_zc = '0;
        end
        if (w_zc > QUARTER_TURN) begin
            w_zc = QUARTER_TURN;
        end
        if (w_qflg.zero) begin
            w_zc = '0;
        end
        n_t = T_W'(w_zc);
        if (w_qflg.neg_x) begin
            n_t = HALF_TURN - n_t;
        end
        if (w_qflg.neg_y) begin
            n_t = -n_t;
        end
    end

    // scale to degree units, halves round up
    logic signed [MUL_W-1:0] w_prod, w_sum;
    logic signed [ANG_W-1:0] r_ang;

    assign w_prod = MUL_W'(r_t) * MUL_W'(DEG_SCALE);
    assign w_sum  = w_prod + RND;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t   <= n_t;
            r_ang <= ANG_W'(w_sum >>> RND_SH);
        end
    end

    assign o_angle = r_ang;
endmodule

`default_nettype wire

[hw/rtl/quaternion_to_euler_angles.sv]
// Quaternion (Q14) to Z-Y-X Euler angles: yaw, pitch, roll in 1/2^ANGLE_FRAC_BITS deg.
// Pipeline: front end, arcsine preparation with its one-bit-per-stage square root,
// CORDIC arctangent, output register.
// One item per cycle unless the output stalls; a stall freezes every stage at once.
// Reset (synchronous, active low) clears the valid bits; no clearing pass.
// Depends on qte_pkg, qte_front, qte_pitch, qte_dly and qte_atan.
`default_nettype none

module quaternion_to_euler_angles #(
    parameter int ANGLE_FRAC_BITS = 6
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // quat_real [15:0], quat_i [31:16], quat_j [47:32], quat_k [63:48]
    input  wire logic [qte_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // yaw_deg [14:0], pitch_deg [28:15], roll_deg [43:29], zero [47:44]
    output logic [qte_pkg::OUT_DATA_W-1:0]         o_m_axis_tdata,
    // degenerate [0]
    output logic [0:0]                             o_m_axis_tuser
);
    import qte_pkg::*;

    localparam int ANG_W = ANGLE_FRAC_BITS + 10;
    localparam int SIDE_LAT = FRONT_LAT + PREP_LAT + ATAN_LAT;
    localparam logic signed [ANG_W-1:0] FULL = ANG_W'(360 << ANGLE_FRAC_BITS);

    logic w_en;
    logic r_out_valid;

    assign w_en            = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // side band: valid and zero-norm flag
    t_side w_side_in, w_side_out;

    assign w_side_in = '{valid: i_s_axis_tvalid, degen: (i_s_axis_tdata == '0)};

    qte_dly #(.WIDTH($bits(t_side)), .DEPTH(SIDE_LAT)) u_side (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_data  (w_side_in),
        .o_data  (w_side_out)
    );

    t_sums w_sums;

    qte_front u_front (
        .i_clk       (i_clk),
        .i_en        (w_en),
        .i_quat_real (signed'(i_s_axis_tdata[QUAT_W-1:0])),
        .i_quat_i    (signed'(i_s_axis_tdata[2*QUAT_W-1:QUAT_W])),
        .i_quat_j    (signed'(i_s_axis_tdata[3*QUAT_W-1:2*QUAT_W])),
        .i_quat_k    (signed'(i_s_axis_tdata[4*QUAT_W-1:3*QUAT_W])),
        .o_sums      (w_sums)
    );

    // hold yaw and roll terms while the arcsine term is prepared
    t_yr_vec w_yr;

    qte_dly #(.WIDTH($bits(t_yr_vec)), .DEPTH(PREP_LAT)) u_yr_dly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_data  (w_sums.yr),
        .o_data  (w_yr)
    );

    logic [NN_W-1:0] w_pc, w_pa;
    logic            w_pneg;

    qte_pitch u_pitch (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_s    (w_sums.pitch_s),
        .i_norm (w_sums.norm),
        .o_c    (w_pc),
        .o_a    (w_pa),
        .o_neg  (w_pneg)
    );

    logic signed [ANG_W-1:0] w_yaw, w_pitch, w_roll;

    qte_atan #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_yaw (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_ax    (CW'(f_mag(w_yr.yaw_x))),
        .i_ay    (CW'(f_mag(w_yr.yaw_y))),
        .i_neg_x (w_yr.yaw_x[SUM_W-1]),
        .i_neg_y (w_yr.yaw_y[SUM_W-1]),
        .o_angle (w_yaw)
    );

    qte_atan #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_roll (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_ax    (CW'(f_mag(w_yr.roll_x))),
        .i_ay    (CW'(f_mag(w_yr.roll_y))),
        .i_neg_x (w_yr.roll_x[SUM_W-1]),
        .i_neg_y (w_yr.roll_y[SUM_W-1]),
        .o_angle (w_roll)
    );

    qte_atan #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_pitch_atan (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_ax    (CW'(w_pc)),
        .i_ay    (CW'(w_pa)),
        .i_neg_x (1'b0),
        .i_neg_y (w_pneg),
        .o_angle (w_pitch)
    );

    // wrap yaw into one turn, force zero angles on a zero norm
    logic signed [ANG_W-1:0] n_yaw_w;
    logic [YAW_W-1:0]        n_yaw, r_yaw;
    logic [PITCH_W-1:0]      n_pitch, r_pitch;
    logic [ROLL_W-1:0]       n_roll, r_roll;
    logic                    r_degen;

    always_comb begin
        n_yaw_w = w_yaw;
        if (n_yaw_w < 0) begin
            n_yaw_w = n_yaw_w + FULL;
        end
        if (n_yaw_w >= FULL) begin
            n_yaw_w = n_yaw_w - FULL;
        end
        n_yaw   = YAW_W'(n_yaw_w);
        n_pitch = PITCH_W'(w_pitch);
        n_roll  = ROLL_W'(w_roll);
        if (w_side_out.degen) begin
            n_yaw   = '0;
            n_pitch = '0;
            n_roll  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_side_out.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_yaw   <= n_yaw;
            r_pitch <= n_pitch;
            r_roll  <= n_roll;
            r_degen <= w_side_out.degen;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_DATA_W'({r_roll, r_pitch, r_yaw});
    assign o_m_axis_tuser  = r_degen;
endmodule

`default_nettype wire
